// File: design/jsk_pkg.sv
// Shared constants and the CORDIC arc table for the joystick sector key events block.
`timescale 1ns / 1ps
package jsk_pkg;

  // Default widths
  localparam int COORD_BITS_DEF = 12;
  localparam int ANGLE_BITS_DEF = 16;

  // Key set
  localparam int NUM_KEYS = 5;
  localparam int KEY_BITS = 3;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [CFG_IDX_BITS-1:0] CFG_S1_LOW   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S1_HIGH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S2_START = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S2_END   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S3_START = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S3_END   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S4_START = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S4_END   = 3'd7;

  localparam logic [CFG_DATA_BITS-1:0] RST_S1_LOW   = 17'd8192;
  localparam logic [CFG_DATA_BITS-1:0] RST_S1_HIGH  = 17'd57344;
  localparam logic [CFG_DATA_BITS-1:0] RST_S2_START = 17'd8192;
  localparam logic [CFG_DATA_BITS-1:0] RST_S2_END   = 17'd24576;
  localparam logic [CFG_DATA_BITS-1:0] RST_S3_START = 17'd24576;
  localparam logic [CFG_DATA_BITS-1:0] RST_S3_END   = 17'd40960;
  localparam logic [CFG_DATA_BITS-1:0] RST_S4_START = 17'd40960;
  localparam logic [CFG_DATA_BITS-1:0] RST_S4_END   = 17'd57344;

  // CORDIC: angle as 32-bit fraction of a turn, coords scaled by 2^30
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
  localparam int SCALE_SHIFT  = 30;
  localparam int TURN_BITS    = 32;
  localparam logic [TURN_BITS-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [TURN_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [TURN_BITS-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [TURN_BITS-1:0] arc_angle(input logic [STEP_BITS-1:0] i);
    logic [TURN_BITS-1:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: design/jsk_in_if.sv
// Sample channel: stick position and button, valid/ready handshake.
`timescale 1ns / 1ps
interface jsk_in_if #(
  parameter int COORD_BITS = jsk_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] stick_x;
  logic signed [COORD_BITS-1:0] stick_y;
  logic                         button_down;

  modport source (output valid, output stick_x, output stick_y, output button_down,
                  input ready);
  modport sink (input valid, input stick_x, input stick_y, input button_down,
                output ready);
endinterface

// File: design/jsk_out_if.sv
// Event channel: key index, press/release and last-of-sample flag.
`timescale 1ns / 1ps
interface jsk_out_if;
  import jsk_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key_index;
  logic                is_press;
  logic                last_event;

  modport source (output valid, output key_index, output is_press, output last_event,
                  input ready);
  modport sink (input valid, input key_index, input is_press, input last_event,
                output ready);
endinterface

// File: design/jsk_queue.sv
// Small register FIFO carrying commands from the front to the back.
`timescale 1ns / 1ps
module jsk_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = jsk_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != CNT_BITS'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

// File: design/jsk_front.sv
// Front end: accepts samples, classifies center/axis cases, runs the iterative CORDIC angle.
`timescale 1ns / 1ps
module jsk_front #(
  parameter int COORD_BITS = jsk_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = jsk_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  jsk_in_if.sink                in_ch,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output logic [ANGLE_BITS+2:0] cmd_data
);
  import jsk_pkg::*;

  // Datapath width: scaled coordinate plus sign and CORDIC growth
  localparam int W    = COORD_BITS + SCALE_SHIFT + 2;
  localparam int DROP = TURN_BITS - ANGLE_BITS;
  localparam logic [TURN_BITS-1:0] Z_FULL = HALF_TURN - (TURN_BITS'(1) << (DROP - 1));

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ITER = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic signed [W-1:0]   cx_r, cx_nxt;
  logic signed [W-1:0]   cy_r, cy_nxt;
  logic [TURN_BITS-1:0]  z_r, z_nxt;
  logic                  center_r, center_nxt;
  logic                  button_r, button_nxt;

  logic                  accept;
  logic                  x_zero, y_zero, x_neg, y_neg;
  logic signed [W-1:0]   x_ext, y_ext;
  logic signed [W-1:0]   dx, dy;
  logic                  cy_pos;
  logic [TURN_BITS:0]    z_round;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Sample classification
  assign x_zero = (in_ch.stick_x == '0);
  assign y_zero = (in_ch.stick_y == '0);
  assign x_neg  = in_ch.stick_x[COORD_BITS-1];
  assign y_neg  = in_ch.stick_y[COORD_BITS-1];
  assign x_ext  = {{(W - COORD_BITS){in_ch.stick_x[COORD_BITS-1]}}, in_ch.stick_x};
  assign y_ext  = {{(W - COORD_BITS){in_ch.stick_y[COORD_BITS-1]}}, in_ch.stick_y};

  // One CORDIC vectoring step; arithmetic shift floors
  assign dx     = cy_r >>> step_r;
  assign dy     = cx_r >>> step_r;
  assign cy_pos = !cy_r[W-1] && (cy_r != '0);

  // Add half a turn, round half up to ANGLE_BITS fraction bits
  assign z_round   = {1'b0, z_r + HALF_TURN} + ((TURN_BITS + 1)'(1) << (DROP - 1));
  assign cmd_valid = (state_r == ST_PUSH);
  assign cmd_data  = {center_r, button_r, z_round[TURN_BITS:DROP]};

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    z_nxt      = z_r;
    center_nxt = center_r;
    button_nxt = button_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          button_nxt = in_ch.button_down;
          center_nxt = x_zero && y_zero;
          step_nxt   = '0;
          cx_nxt     = (x_neg ? -x_ext : x_ext) <<< SCALE_SHIFT;
          cy_nxt     = (x_neg ? -y_ext : y_ext) <<< SCALE_SHIFT;
          // Axis angles are set up so the final rounding lands exactly
          if (y_zero && !x_neg) begin
            z_nxt     = '0;
            state_nxt = ST_PUSH;
          end else if (y_zero) begin
            z_nxt     = Z_FULL;
            state_nxt = ST_PUSH;
          end else if (x_zero && !y_neg) begin
            z_nxt     = QUARTER_TURN;
            state_nxt = ST_PUSH;
          end else if (x_zero) begin
            z_nxt     = THREE_QUARTER_TURN;
            state_nxt = ST_PUSH;
          end else begin
            z_nxt     = x_neg ? HALF_TURN : '0;
            state_nxt = ST_ITER;
          end
        end
      end
      ST_ITER: begin
        if (cy_pos) begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          z_nxt  = z_r + arc_angle(step_r);
        end else begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          z_nxt  = z_r - arc_angle(step_r);
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (cmd_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    z_r      <= z_nxt;
    center_r <= center_nxt;
    button_r <= button_nxt;
  end
endmodule

// File: design/jsk_back.sv
// Back end: sector compare, held-key flags, and event sequencing onto the output channel.
`timescale 1ns / 1ps
module jsk_back #(
  parameter int ANGLE_BITS = jsk_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [ANGLE_BITS+2:0]             cmd_data,
  input  logic                              cfg_we,
  input  logic [jsk_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [jsk_pkg::CFG_DATA_BITS-1:0] cfg_data,
  jsk_out_if.source                         out_ch
);
  import jsk_pkg::*;

  localparam int A_BITS   = ANGLE_BITS + 1;
  localparam int CMP_BITS = (A_BITS > CFG_DATA_BITS) ? A_BITS : CFG_DATA_BITS;

  // Sector edges
  logic [CFG_DATA_BITS-1:0] s1_low_r, s1_high_r;
  logic [CFG_DATA_BITS-1:0] s2_start_r, s2_end_r;
  logic [CFG_DATA_BITS-1:0] s3_start_r, s3_end_r;
  logic [CFG_DATA_BITS-1:0] s4_start_r, s4_end_r;

  logic [NUM_KEYS-1:0] held_r, held_nxt;
  logic [NUM_KEYS-1:0] want_r, want_nxt;
  logic [NUM_KEYS-1:0] pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic                out_press_r, out_press_nxt;
  logic                out_last_r, out_last_nxt;

  logic                center, button;
  logic [CMP_BITS-1:0] angle;
  logic [NUM_KEYS-1:0] want_new, emit_new;
  logic                pop, take, can_load;
  logic [KEY_BITS-1:0] sel_key;
  logic [NUM_KEYS-1:0] sel_mask;

  // Command fields
  assign center = cmd_data[ANGLE_BITS+2];
  assign button = cmd_data[ANGLE_BITS+1];
  assign angle  = CMP_BITS'(cmd_data[A_BITS-1:0]);

  // Sector membership for a new sample
  always_comb begin
    want_new[0] = button;
    if (center) begin
      want_new[NUM_KEYS-1:1] = '0;
      emit_new = {{(NUM_KEYS - 1){1'b1}}, button ^ held_r[0]};
    end else begin
      want_new[1] = (angle <= CMP_BITS'(s1_low_r)) || (angle > CMP_BITS'(s1_high_r));
      want_new[2] = (angle > CMP_BITS'(s2_start_r)) && (angle <= CMP_BITS'(s2_end_r));
      want_new[3] = (angle > CMP_BITS'(s3_start_r)) && (angle <= CMP_BITS'(s3_end_r));
      want_new[4] = (angle > CMP_BITS'(s4_start_r)) && (angle <= CMP_BITS'(s4_end_r));
      emit_new = want_new ^ held_r;
    end
  end

  // Lowest pending key goes out first
  always_comb begin
    sel_key  = '0;
    sel_mask = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        sel_key  = KEY_BITS'(k);
        sel_mask = NUM_KEYS'(1) << k;
      end
    end
  end

  assign cmd_ready    = (pend_r == '0);
  assign pop          = cmd_valid && cmd_ready;
  assign take         = out_valid_r && out_ch.ready;
  assign can_load     = !out_valid_r || take;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.key_index  = out_key_r;
  assign out_ch.is_press   = out_press_r;
  assign out_ch.last_event = out_last_r;

  // Event sequencer
  always_comb begin
    held_nxt      = held_r;
    want_nxt      = want_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_press_nxt = out_press_r;
    out_last_nxt  = out_last_r;
    if (pend_r != '0 && can_load) begin
      pend_nxt      = pend_r & ~sel_mask;
      out_valid_nxt = 1'b1;
      out_key_nxt   = sel_key;
      out_press_nxt = |(want_r & sel_mask);
      out_last_nxt  = ((pend_r & ~sel_mask) == '0);
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      held_nxt = want_new;
      want_nxt = want_new;
      pend_nxt = emit_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Beat payload
  always_ff @(posedge clk) begin
    want_r      <= want_nxt;
    out_key_r   <= out_key_nxt;
    out_press_r <= out_press_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_low_r   <= RST_S1_LOW;
      s1_high_r  <= RST_S1_HIGH;
      s2_start_r <= RST_S2_START;
      s2_end_r   <= RST_S2_END;
      s3_start_r <= RST_S3_START;
      s3_end_r   <= RST_S3_END;
      s4_start_r <= RST_S4_START;
      s4_end_r   <= RST_S4_END;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_S1_LOW:   s1_low_r   <= cfg_data;
        CFG_S1_HIGH:  s1_high_r  <= cfg_data;
        CFG_S2_START: s2_start_r <= cfg_data;
        CFG_S2_END:   s2_end_r   <= cfg_data;
        CFG_S3_START: s3_start_r <= cfg_data;
        CFG_S3_END:   s3_end_r   <= cfg_data;
        CFG_S4_START: s4_start_r <= cfg_data;
        CFG_S4_END:   s4_end_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end
endmodule

// File: design/joystick_sector_key_events_unit.sv
// Top level of the joystick sector key events block.
`timescale 1ns / 1ps
// Turns joystick samples (signed x, y and a push button) into key press and
// release beats for five keys: key 0 is the button, keys 1 to 4 are direction
// sectors of the stick angle atan2(y,x)+pi, where 2^ANGLE_BITS is a full turn.
// A beat goes out only when a key's held flag changes; a sample at exact center
// releases all four direction keys whether held or not. The last beat of a
// sample carries last_event. The front end takes no new sample before handing
// off the last; the angle takes 30 CORDIC steps of one shared add/shift unit,
// which center and axis samples skip. A two-entry command queue feeds the
// back end, which does the sector compare as it takes a sample and sends one
// beat per cycle while the sink is ready. The user must write sector edges
// through the cfg_ port while no sample is in flight; it is not enforced.
module joystick_sector_key_events_unit #(
  parameter int COORD_BITS = jsk_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = jsk_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  jsk_in_if.sink                            in_ch,
  jsk_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [jsk_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [jsk_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import jsk_pkg::*;

  localparam int CMD_BITS = ANGLE_BITS + 3;

  logic                f_valid, f_ready;
  logic [CMD_BITS-1:0] f_data;
  logic                b_valid, b_ready;
  logic [CMD_BITS-1:0] b_data;

  // Sample intake and angle
  jsk_front #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  // Decoupling queue
  jsk_queue #(
    .WIDTH (CMD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // Key state and event output
  jsk_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_data  (b_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );
endmodule

// File: sim/tb_joystick_sector_key_events_unit.sv
// Self-checking testbench: joystick samples in, key press/release beats checked against a predictor.
`timescale 1ns / 1ps
module tb_joystick_sector_key_events_unit;
  import jsk_pkg::*;

  localparam int COORD_W        = COORD_BITS_DEF;
  localparam int ANGLE_W        = ANGLE_BITS_DEF;
  localparam int EDGE_W         = CFG_DATA_BITS;
  localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (COORD_W - 1));
  localparam int DIRECTED_COUNT = 24;
  localparam int PHASE_COUNT    = 6;
  localparam int SETTLE_CYCLES  = 120;
  localparam int CYCLE_LIMIT    = 400000;
  localparam longint COORD_UNIT = 64'sd1 <<< SCALE_SHIFT;
  localparam logic [TURN_BITS:0] ROUND_HALF = (TURN_BITS + 1)'(1) << (TURN_BITS - ANGLE_W - 1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                press;
    logic                last;
  } key_event_t;

  // n_typed < 0: expectation comes from the predictor
  typedef struct {
    int         x;
    int         y;
    bit         btn;
    int         n_typed;
    key_event_t ev [NUM_KEYS];
  } stim_row_t;

  typedef enum int {EDGES_RANDOM, EDGES_ZERO, EDGES_FULL_TURN, EDGES_ALL_ONES} edge_plan_t;

  localparam key_event_t NO_EVENT = '0;

  localparam logic [CFG_IDX_BITS-1:0] EDGE_REGS [8] = '{
    CFG_S1_LOW, CFG_S1_HIGH, CFG_S2_START, CFG_S2_END,
    CFG_S3_START, CFG_S3_END, CFG_S4_START, CFG_S4_END
  };

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TURN_BITS-1:0] ARC_STEPS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [EDGE_W-1:0]        cfg_data;

  jsk_in_if #(.COORD_BITS(COORD_W)) in_ch ();
  jsk_out_if out_ch ();

  joystick_sector_key_events_unit #(
    .COORD_BITS(COORD_W),
    .ANGLE_BITS(ANGLE_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state
  logic [EDGE_W-1:0] sector_edge [8];
  logic              held_keys [NUM_KEYS];
  key_event_t        step_events [$];
  key_event_t        pending_events [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit no_idle        = 1'b0;
  bit button_level   = 1'b0;

  function automatic key_event_t kev(input int k, input bit p, input bit l);
    key_event_t e;
    e.key   = KEY_BITS'(k);
    e.press = p;
    e.last  = l;
    return e;
  endfunction

  // Directed samples; typed expectations assume reset edges
  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    // center from reset: all four direction keys released even though none held
    '{0, 0, 1'b0, 4, '{kev(1,0,0), kev(2,0,0), kev(3,0,0), kev(4,0,1), NO_EVENT}},
    '{0, 0, 1'b1, 5, '{kev(0,1,0), kev(1,0,0), kev(2,0,0), kev(3,0,0), kev(4,0,1)}},
    // axis samples land on exact angles
    '{COORD_MAX, 0, 1'b1, 1, '{kev(3,1,1), NO_EVENT, NO_EVENT, NO_EVENT, NO_EVENT}},
    '{COORD_MIN, 0, 1'b0, 3, '{kev(0,0,0), kev(1,1,0), kev(3,0,1), NO_EVENT, NO_EVENT}},
    '{0, COORD_MAX, 1'b0, 2, '{kev(1,0,0), kev(4,1,1), NO_EVENT, NO_EVENT, NO_EVENT}},
    '{0, COORD_MIN, 1'b0, 2, '{kev(2,1,0), kev(4,0,1), NO_EVENT, NO_EVENT, NO_EVENT}},
    // same sector again: nothing changes
    '{0, -1, 1'b0, 0, '{default: NO_EVENT}},
    '{-1, 0, 1'b1, 3, '{kev(0,1,0), kev(1,1,0), kev(2,0,1), NO_EVENT, NO_EVENT}},
    '{1, 0, 1'b1, 2, '{kev(1,0,0), kev(3,1,1), NO_EVENT, NO_EVENT, NO_EVENT}},
    // diagonals, corners and near-axis points
    '{COORD_MIN, COORD_MIN, 1'b0, -1, '{default: NO_EVENT}},
    '{COORD_MAX, COORD_MAX, 1'b0, -1, '{default: NO_EVENT}},
    '{COORD_MAX, COORD_MIN, 1'b1, -1, '{default: NO_EVENT}},
    '{COORD_MIN, COORD_MAX, 1'b1, -1, '{default: NO_EVENT}},
    '{1, 1, 1'b0, -1, '{default: NO_EVENT}},
    '{-1, 1, 1'b0, -1, '{default: NO_EVENT}},
    '{1, -1, 1'b1, -1, '{default: NO_EVENT}},
    '{-1, -1, 1'b1, -1, '{default: NO_EVENT}},
    '{3, -7, 1'b0, -1, '{default: NO_EVENT}},
    '{-1000, 5, 1'b0, -1, '{default: NO_EVENT}},
    '{1234, -567, 1'b1, -1, '{default: NO_EVENT}},
    '{COORD_MIN, -1, 1'b0, -1, '{default: NO_EVENT}},
    '{COORD_MAX, 1, 1'b0, -1, '{default: NO_EVENT}},
    // center with the button held, then center with it let go
    '{0, 0, 1'b1, -1, '{default: NO_EVENT}},
    '{0, 0, 1'b0, 5, '{kev(0,0,0), kev(1,0,0), kev(2,0,0), kev(3,0,0), kev(4,0,1)}}
  };

  edge_plan_t edge_plans [PHASE_COUNT] = '{
    EDGES_RANDOM, EDGES_ZERO, EDGES_RANDOM, EDGES_FULL_TURN, EDGES_ALL_ONES, EDGES_RANDOM
  };

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("joystick_sector_key_events_unit: mismatch");
      $finish;
    end
  end

  function automatic void reset_predictor();
    int k;
    sector_edge[CFG_S1_LOW]   = RST_S1_LOW;
    sector_edge[CFG_S1_HIGH]  = RST_S1_HIGH;
    sector_edge[CFG_S2_START] = RST_S2_START;
    sector_edge[CFG_S2_END]   = RST_S2_END;
    sector_edge[CFG_S3_START] = RST_S3_START;
    sector_edge[CFG_S3_END]   = RST_S3_END;
    sector_edge[CFG_S4_START] = RST_S4_START;
    sector_edge[CFG_S4_END]   = RST_S4_END;
    for (k = 0; k < NUM_KEYS; k++) held_keys[k] = 1'b0;
  endfunction

  // Stick angle atan2(y,x)+pi, full turn = 2^ANGLE_W
  function automatic logic [EDGE_W-1:0] stick_turn(input logic signed [COORD_W-1:0] sx,
                                                   input logic signed [COORD_W-1:0] sy);
    longint               cx, cy, dx, dy;
    logic [TURN_BITS-1:0] acc;
    logic [TURN_BITS:0]   rounded;
    int                   i;
    // axis points are exact
    if (sy == 0 && sx > 0) return EDGE_W'(64'd1 << (ANGLE_W - 1));
    if (sy == 0 && sx < 0) return EDGE_W'(64'd1 << ANGLE_W);
    if (sx == 0 && sy > 0) return EDGE_W'(64'd3 << (ANGLE_W - 2));
    if (sx == 0 && sy < 0) return EDGE_W'(64'd1 << (ANGLE_W - 2));
    cx  = longint'(sx) * COORD_UNIT;
    cy  = longint'(sy) * COORD_UNIT;
    acc = '0;
    // left half plane: pre-rotate by half a turn
    if (sx < 0) begin
      cx  = -cx;
      cy  = -cy;
      acc = HALF_TURN;
    end
    // vectoring toward y = 0; arithmetic shifts floor
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        acc = acc + ARC_STEPS[i];
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        acc = acc - ARC_STEPS[i];
      end
    end
    acc     = acc + HALF_TURN;
    rounded = ({1'b0, acc} + ROUND_HALF) >> (TURN_BITS - ANGLE_W);
    return EDGE_W'(rounded);
  endfunction

  function automatic void follow_key(input int k, input logic want);
    if (want != held_keys[k]) begin
      held_keys[k] = want;
      step_events.push_back(kev(k, want, 1'b0));
    end
  endfunction

  // Key beats caused by one sample, in order, into step_events
  function automatic void predict_key_events(input logic signed [COORD_W-1:0] sx,
                                             input logic signed [COORD_W-1:0] sy,
                                             input logic btn);
    logic [EDGE_W-1:0] turn;
    key_event_t        tail;
    int                k;
    step_events.delete();
    follow_key(0, btn);
    if (sx == 0 && sy == 0) begin
      // center: unconditional release of every direction key
      for (k = 1; k < NUM_KEYS; k++) begin
        held_keys[k] = 1'b0;
        step_events.push_back(kev(k, 1'b0, 1'b0));
      end
    end else begin
      turn = stick_turn(sx, sy);
      follow_key(1, turn <= sector_edge[CFG_S1_LOW] || turn > sector_edge[CFG_S1_HIGH]);
      follow_key(2, sector_edge[CFG_S2_START] < turn && turn <= sector_edge[CFG_S2_END]);
      follow_key(3, sector_edge[CFG_S3_START] < turn && turn <= sector_edge[CFG_S3_END]);
      follow_key(4, sector_edge[CFG_S4_START] < turn && turn <= sector_edge[CFG_S4_END]);
    end
    if (step_events.size() > 0) begin
      tail      = step_events.pop_back();
      tail.last = 1'b1;
      step_events.push_back(tail);
    end
  endfunction

  function automatic int draw_coord();
    logic signed [COORD_W-1:0] r;
    r = COORD_W'($urandom);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return int'($urandom_range(0, 8)) - 4;
      2:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default: return r;
    endcase
  endfunction

  function automatic logic [EDGE_W-1:0] draw_edge(input edge_plan_t plan);
    case (plan)
      EDGES_ZERO:      return '0;
      EDGES_FULL_TURN: return EDGE_W'(64'd1 << ANGLE_W);
      EDGES_ALL_ONES:  return '1;
      default: begin
        case ($urandom_range(0, 9))
          0:       return '0;
          1:       return EDGE_W'(64'd1 << ANGLE_W);
          2:       return '1;
          3:       return EDGE_W'($urandom);
          default: return EDGE_W'($urandom_range(0, 1 << ANGLE_W));
        endcase
      end
    endcase
  endfunction

  // One sample beat: optional gap, hold until taken, then predict
  task automatic drive_sample(input int sx, input int sy, input bit btn);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.stick_x     <= COORD_W'(sx);
    in_ch.stick_y     <= COORD_W'(sy);
    in_ch.button_down <= btn;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_key_events(COORD_W'(sx), COORD_W'(sy), btn);
  endtask

  task automatic end_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // Idle the block: no beat pending and no sample left in flight
  task automatic settle();
    end_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_edges(input edge_plan_t plan);
    int                r;
    logic [EDGE_W-1:0] v;
    for (r = 0; r < 8; r++) begin
      v = draw_edge(plan);
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= EDGE_REGS[r];
      cfg_data  <= v;
      sector_edge[EDGE_REGS[r]] = v;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic play_random_items(input int count);
    int i, sx, sy;
    for (i = 0; i < count; i++) begin
      if (i % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // occasionally hold off until every beat has come back
      if ($urandom_range(0, 24) == 0) begin
        end_input();
        wait_drained();
      end
      if ($urandom_range(0, 3) == 0) button_level = ~button_level;
      sx = draw_coord();
      sy = draw_coord();
      case ($urandom_range(0, 15))
        0: begin
          sx = 0;
          sy = 0;
        end
        1: sx = 0;
        2: sy = 0;
        default: ;
      endcase
      drive_sample(sx, sy, button_level);
      foreach (step_events[j]) pending_events.push_back(step_events[j]);
    end
  endtask

  // Event sink: random stalls, check each beat against the oldest expectation
  initial begin : event_sink
    int         gap;
    key_event_t got, want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 16);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.key   = out_ch.key_index;
      got.press = out_ch.is_press;
      got.last  = out_ch.last_event;
      if (pending_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat: expected none, got key %0d press %0b last %0b",
                 $time, got.key, got.press, got.last);
      end else begin
        want = pending_events.pop_front();
        if (got.key !== want.key || got.press !== want.press || got.last !== want.last) begin
          mismatch_count++;
          $display(
            "%0t: mismatch: expected key %0d press %0b last %0b, got key %0d press %0b last %0b",
            $time, want.key, want.press, want.last, got.key, got.press, got.last);
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int i, r;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_S1_LOW;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.stick_x     = '0;
    in_ch.stick_y     = '0;
    in_ch.button_down = 1'b0;
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, reset edges
    for (i = 0; i < DIRECTED_COUNT; i++) begin
      drive_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].btn);
      if (directed_rows[i].n_typed < 0) begin
        foreach (step_events[j]) pending_events.push_back(step_events[j]);
      end else begin
        for (r = 0; r < directed_rows[i].n_typed; r++)
          pending_events.push_back(directed_rows[i].ev[r]);
      end
    end
    button_level = 1'b0;
    play_random_items(20);

    // one edge setting per phase, written while idle
    for (i = 0; i < PHASE_COUNT; i++) begin
      settle();
      write_edges(edge_plans[i]);
      play_random_items(30);
    end
    settle();

    if (mismatch_count == 0) begin
      $display("joystick_sector_key_events_unit: match");
    end else begin
      $display("joystick_sector_key_events_unit: mismatch");
    end
    $finish;
  end

endmodule
